/* hdl/imm_pkg.sv */
// ----------------------------------------------------------------------------
// imm_pkg
// Types, codes and sizes shared by the integer matrix multiply block.
// ----------------------------------------------------------------------------
package imm_pkg;

  localparam int MAX_DIM    = 8;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = 3;                // row or column index
  localparam int DIM_W      = IDX_W + 1;        // a size, 1..MAX_DIM
  localparam int ADDR_W     = 2 * IDX_W;        // store address {row, col}
  localparam int DEPTH      = MAX_DIM * MAX_DIM;
  localparam int CFG_IDX_W  = 2;

  localparam logic [1:0] OP_WR_A    = 2'd0;
  localparam logic [1:0] OP_WR_B    = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_A_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 2'd3;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef struct packed {
    logic [1:0]                   op;
    logic [IDX_W-1:0]             elem_row;
    logic [IDX_W-1:0]             elem_col;
    logic signed [DATA_WIDTH-1:0] elem_value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]             out_row;
    logic [IDX_W-1:0]             out_col;
    logic signed [DATA_WIDTH-1:0] product_value;
    logic                         status;
    logic                         last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_ACC,
    ST_EMIT,
    ST_FAIL
  } state_t;

  // Saturate a written size into 1..MAX_DIM.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] x;
    x = v;
    if (x == '0) x = DIM_W'(1);
    if (x > DIM_W'(MAX_DIM)) x = DIM_W'(MAX_DIM);
    return x;
  endfunction

endpackage

/* hdl/imm_ram.sv */
// ----------------------------------------------------------------------------
// imm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module imm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hdl/integer_matrix_multiply.sv */
// ----------------------------------------------------------------------------
// integer_matrix_multiply
// Loads two signed matrices into RAM stores and streams their product.
// ----------------------------------------------------------------------------
// Load items: one per cycle while idle, written to the store RAM in the
// accept cycle. Compute item: each dot-product term passes through RAM read,
// multiply and accumulate on one shared multiplier and adder, then each entry
// is loaded into the output register, waiting while the output stalls; a size
// mismatch gives one failure item. No new item is taken until the run is done.
// Reset sets all sizes to 1; the stores are not cleared (no clearing pass).
// ----------------------------------------------------------------------------
module integer_matrix_multiply
  import imm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  state_t state_r, state_nxt;

  logic [DIM_W-1:0] a_rows_r, a_cols_r, b_rows_r, b_cols_r;

  logic [IDX_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [DATA_WIDTH-1:0] acc_r, acc_nxt;
  logic [DATA_WIDTH-1:0] prod_r;
  logic [DATA_WIDTH-1:0] rd_a, rd_b;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic in_accept, out_free;
  logic last_k, last_j, last_i;
  logic wr_a_en, wr_b_en;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign last_k    = ({1'b0, k_r} + DIM_W'(1)) == b_rows_r;
  assign last_j    = ({1'b0, j_r} + DIM_W'(1)) == b_cols_r;
  assign last_i    = ({1'b0, i_r} + DIM_W'(1)) == a_rows_r;

  assign cfg_ready = 1'b1;
  assign wr_a_en   = in_accept && (in_data.op == OP_WR_A);
  assign wr_b_en   = in_accept && (in_data.op == OP_WR_B);

  // ---------------- stores ----------------
  imm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_store_a (
    .clk     (clk),
    .wr_en   (wr_a_en),
    .wr_addr ({in_data.elem_row, in_data.elem_col}),
    .wr_data (in_data.elem_value),
    .rd_addr ({i_r, k_r}),
    .rd_data (rd_a)
  );

  imm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_store_b (
    .clk     (clk),
    .wr_en   (wr_b_en),
    .wr_addr ({in_data.elem_row, in_data.elem_col}),
    .wr_data (in_data.elem_value),
    .rd_addr ({k_r, j_r}),
    .rd_data (rd_b)
  );

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r <= DIM_W'(1);
      a_cols_r <= DIM_W'(1);
      b_rows_r <= DIM_W'(1);
      b_cols_r <= DIM_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_A_ROWS: a_rows_r <= clamp_dim(cfg_data);
        REG_A_COLS: a_cols_r <= clamp_dim(cfg_data);
        REG_B_ROWS: b_rows_r <= clamp_dim(cfg_data);
        REG_B_COLS: b_cols_r <= clamp_dim(cfg_data);
        default: ;
      endcase
    end
  end

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept && (in_data.op == OP_COMPUTE)) begin
          state_nxt = (a_cols_r == b_rows_r) ? ST_READ : ST_FAIL;
        end
      end
      ST_READ: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_ACC;
      ST_ACC:  state_nxt = last_k ? ST_EMIT : ST_READ;
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = (last_i && last_j) ? ST_IDLE : ST_READ;
        end
      end
      ST_FAIL: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- outputs and datapath ----------------
  always_comb begin
    in_stall      = 1'b1;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        i_nxt    = '0;
        j_nxt    = '0;
        k_nxt    = '0;
        acc_nxt  = '0;
      end
      ST_READ: ;
      ST_MUL:  ;
      ST_ACC: begin
        acc_nxt = acc_r + prod_r;
        if (!last_k) begin
          k_nxt = k_r + IDX_W'(1);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.out_row       = i_r;
          out_data_nxt.out_col       = j_r;
          out_data_nxt.product_value = acc_r;
          out_data_nxt.status        = STATUS_OK;
          out_data_nxt.last          = last_i && last_j;
          acc_nxt                    = '0;
          k_nxt                      = '0;
          // advance column, wrap into the next row
          if (last_j) begin
            j_nxt = '0;
            i_nxt = i_r + IDX_W'(1);
          end else begin
            j_nxt = j_r + IDX_W'(1);
          end
        end
      end
      ST_FAIL: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.out_row       = '0;
          out_data_nxt.out_col       = '0;
          out_data_nxt.product_value = '0;
          out_data_nxt.status        = STATUS_FAIL;
          out_data_nxt.last          = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
    // low bits of the signed product equal those of the unsigned one
    prod_r     <= rd_a * rd_b;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- assertions ----------------
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_EMIT || $past(state_r) == ST_FAIL))
    else $error("result item appeared outside an emit state");

  a_fail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == STATUS_FAIL) |-> out_data_r.last)
    else $error("failure item not marked last");

  a_compute_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_data.op == OP_COMPUTE) |=> (state_r == ST_READ || state_r == ST_FAIL))
    else $error("compute item did not start a run");

  a_mul_then_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |=> (state_r == ST_ACC))
    else $error("multiply not followed by accumulate");

  a_no_store_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_a_en || wr_b_en) |-> (state_r == ST_IDLE))
    else $error("store written during a run");

endmodule
